[sv/wth_pkg.sv]
// Shared types, constants and byte helpers for the word tokenizer and hash block.
`default_nettype none

package wth_pkg;

  // Field and register widths.
  localparam int HASH_W       = 32;
  localparam int BASE_W       = 16;
  localparam int BCOUNT_W     = 21;
  localparam int BUCKET_W     = 20;
  localparam int WLEN_W       = 16;
  localparam int LENGTH_BITS  = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = BCOUNT_W;
  localparam int DIV_CNT_W    = $clog2(HASH_W + 1);

  // Reset values and limits of the configuration registers.
  localparam logic [BASE_W-1:0]   BASE_RESET    = BASE_W'(65);
  localparam logic [BCOUNT_W-1:0] BUCKETS_RESET = BCOUNT_W'(100001);
  localparam logic [BCOUNT_W-1:0] BUCKETS_MAX   = BCOUNT_W'(1048576);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_BASE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT = CFG_IDX_W'(1);

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } wth_state_t;

  // Commands from the sequencer to the hash accumulator.
  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic clr;
  } wth_acc_ctrl_t;

  // Whitespace, delimiters, the curly apostrophe bytes and NUL split words.
  function automatic logic is_separator(input logic [7:0] b);
    logic sep;
    unique case (b)
      8'h00, 8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D,
      8'h2E, 8'h2C, 8'h27, 8'h22, 8'h3F, 8'h29, 8'h28,
      8'hE2, 8'h80, 8'h99: sep = 1'b1;
      default:             sep = 1'b0;
    endcase
    return sep;
  endfunction

  // Lowercase for ASCII A-Z only.
  function automatic logic [7:0] to_lower(input logic [7:0] b);
    logic [7:0] r;
    if (b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'h20;
    end else begin
      r = b;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/word_tokenize_and_hash.sv]
// Each accepted byte passes through a multiply step and an add step; a byte that ends a
// word then also takes the 32-step serial remainder pass before its result is loaded.
// The block takes one item at a time through the shared multiply and remainder units and
// accepts no new byte until the last result is loaded, which waits while the output stalls.
// Synchronous active-low reset restores hash_base 65, bucket_count 100001 and clears
// the word state; no clearing pass is needed.
`default_nettype none

module word_tokenize_and_hash (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [7:0]                        in_text_byte,
  input  wire logic                              in_end_of_text,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_is_word_byte,
  output logic [7:0]                             out_lower_byte,
  output logic                                   out_word_done,
  output logic [wth_pkg::BUCKET_W-1:0]           out_bucket,
  output logic [wth_pkg::WLEN_W-1:0]             out_word_length,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [wth_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [wth_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import wth_pkg::*;

  wth_state_t           state_r, state_nxt;
  wth_acc_ctrl_t        acc_ctrl;
  logic [BASE_W-1:0]    hash_base_r;
  logic [BCOUNT_W-1:0]  bucket_count_r;
  logic [BCOUNT_W-1:0]  divisor;
  logic [7:0]           byte_r;
  logic                 eot_r;
  logic                 done_r, done_nxt;
  logic [WLEN_W-1:0]    wlen_r;
  logic                 word_byte;
  logic [7:0]           lower_byte;
  logic                 in_word;
  logic [HASH_W-1:0]    hash_sum;
  logic [LENGTH_BITS-1:0] length_count;
  logic [WLEN_W-1:0]    wlen_sat;
  logic                 mod_start;
  logic                 mod_idle;
  logic [BUCKET_W-1:0]  remainder;
  logic                 out_free;
  logic                 out_load;
  logic                 out_done_val;
  logic                 out_valid_r;
  logic                 out_word_byte_r;
  logic [7:0]           out_lower_r;
  logic                 out_done_r;
  logic [BUCKET_W-1:0]  out_bucket_r;
  logic [WLEN_W-1:0]    out_wlen_r;

  // Configuration registers; an oversized bucket count saturates.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_base_r    <= BASE_RESET;
      bucket_count_r <= BUCKETS_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_HASH_BASE) begin
        hash_base_r <= cfg_data[BASE_W-1:0];
      end else if (cfg_index == CFG_BUCKET_COUNT) begin
        bucket_count_r <= (cfg_data > BUCKETS_MAX) ? BUCKETS_MAX : cfg_data;
      end
    end
  end

  // A bucket count of zero acts as one.
  assign divisor = (bucket_count_r == '0) ? BCOUNT_W'(1) : bucket_count_r;

  // Word length reported on 16 bits, saturating.
  assign wlen_sat = (32'(length_count) > 32'hFFFF) ? '1 : WLEN_W'(length_count);

  wth_accum u_accum (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (acc_ctrl),
    .byte_in      (byte_r),
    .hash_base    (hash_base_r),
    .word_byte    (word_byte),
    .lower_byte   (lower_byte),
    .in_word      (in_word),
    .hash_sum     (hash_sum),
    .length_count (length_count)
  );

  wth_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (hash_sum),
    .divisor   (divisor),
    .idle      (mod_idle),
    .remainder (remainder)
  );

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);

  // Sequencer: multiply, add, then an optional remainder pass before the result.
  always_comb begin
    state_nxt       = state_r;
    acc_ctrl.mul_en = 1'b0;
    acc_ctrl.acc_en = 1'b0;
    acc_ctrl.clr    = 1'b0;
    mod_start       = 1'b0;
    out_load        = 1'b0;
    out_done_val    = done_r;
    done_nxt        = done_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        acc_ctrl.mul_en = 1'b1;
        state_nxt       = ST_ACC;
      end
      ST_ACC: begin
        acc_ctrl.acc_en = 1'b1;
        done_nxt        = word_byte ? eot_r : in_word;
        out_done_val    = 1'b0;
        if (done_nxt) begin
          state_nxt = ST_LOAD;
        end else if (out_free) begin
          out_load     = 1'b1;
          acc_ctrl.clr = eot_r;
          state_nxt    = ST_IDLE;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_LOAD: begin
        mod_start    = 1'b1;
        acc_ctrl.clr = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        if (mod_idle) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load     = 1'b1;
          acc_ctrl.clr = eot_r;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Item capture and per-item bookkeeping.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_text_byte;
      eot_r  <= in_end_of_text;
    end
    done_r <= done_nxt;
    if (state_r == ST_LOAD) begin
      wlen_r <= wlen_sat;
    end
  end

  // Output register parts the result channel from the sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word_byte_r <= word_byte;
      out_lower_r     <= lower_byte;
      out_done_r      <= out_done_val;
      out_bucket_r    <= out_done_val ? remainder : '0;
      out_wlen_r      <= out_done_val ? wlen_r : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_is_word_byte = out_word_byte_r;
  assign out_lower_byte   = out_lower_r;
  assign out_word_done    = out_done_r;
  assign out_bucket       = out_bucket_r;
  assign out_word_length  = out_wlen_r;

endmodule

`default_nettype wire

[sv/wth_accum.sv]
// Word state and polynomial hash accumulator: one multiply step, then one add step.
`default_nettype none

module wth_accum (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire wth_pkg::wth_acc_ctrl_t            ctrl,
  input  wire logic [7:0]                        byte_in,
  input  wire logic [wth_pkg::BASE_W-1:0]        hash_base,
  output logic                                   word_byte,
  output logic [7:0]                             lower_byte,
  output logic                                   in_word,
  output logic [wth_pkg::HASH_W-1:0]             hash_sum,
  output logic [wth_pkg::LENGTH_BITS-1:0]        length_count
);
  import wth_pkg::*;

  logic                   in_word_r;
  logic [HASH_W-1:0]      hash_r;
  logic [HASH_W-1:0]      power_r;
  logic [LENGTH_BITS-1:0] len_r;
  logic [HASH_W-1:0]      prod_r;
  logic [HASH_W-1:0]      pow_next_r;
  logic [HASH_W-1:0]      term;
  logic [HASH_W-1:0]      prod_nxt;
  logic [HASH_W-1:0]      pow_nxt;
  logic [LENGTH_BITS-1:0] len_max;

  // Classify the byte and form its sign-extended hash term.
  always_comb begin
    word_byte  = !is_separator(byte_in);
    lower_byte = word_byte ? to_lower(byte_in) : 8'h00;
    term       = {{(HASH_W-8){lower_byte[7]}}, lower_byte};
    prod_nxt   = term * power_r;
    pow_nxt    = power_r * {{(HASH_W-BASE_W){1'b0}}, hash_base};
    len_max    = '1;
  end

  // Products are registered before the add into the running hash.
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r     <= prod_nxt;
      pow_next_r <= pow_nxt;
    end
  end

  // Word state: cleared at word end and end of text, updated by each word byte.
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clr) begin
      in_word_r <= 1'b0;
      hash_r    <= '0;
      power_r   <= HASH_W'(1);
      len_r     <= '0;
    end else if (ctrl.acc_en && word_byte) begin
      in_word_r <= 1'b1;
      hash_r    <= hash_r + prod_r;
      power_r   <= pow_next_r;
      if (len_r != len_max) begin
        len_r <= len_r + LENGTH_BITS'(1);
      end
    end
  end

  assign in_word      = in_word_r;
  assign hash_sum     = hash_r;
  assign length_count = len_r;

endmodule

`default_nettype wire

[sv/wth_mod.sv]
// Serial remainder unit: one shift and compare-subtract per cycle over the 32-bit hash.
`default_nettype none

module wth_mod (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [wth_pkg::HASH_W-1:0]    dividend,
  input  wire logic [wth_pkg::BCOUNT_W-1:0]  divisor,
  output logic                               idle,
  output logic [wth_pkg::BUCKET_W-1:0]       remainder
);
  import wth_pkg::*;

  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [HASH_W-1:0]    dvd_r, dvd_nxt;
  logic [BCOUNT_W-1:0]  rem_r, rem_nxt;
  logic [BCOUNT_W:0]    trial;

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  always_comb begin
    cnt_nxt = cnt_r;
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    trial   = {rem_r, dvd_r[HASH_W-1]};
    if (start) begin
      cnt_nxt = DIV_CNT_W'(HASH_W);
      dvd_nxt = dividend;
      rem_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      dvd_nxt = {dvd_r[HASH_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = BCOUNT_W'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = BCOUNT_W'(trial);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  // The remainder stays below the divisor, which is at most 2^20.
  assign idle      = (cnt_r == '0);
  assign remainder = rem_r[BUCKET_W-1:0];

endmodule

`default_nettype wire
